// File: src/tts_pkg.sv
`default_nettype none

package tts_pkg;

  localparam int unsigned TaskSlotsDef = 8;
  localparam logic [3:0]  MaxDue       = 4'd8;
  localparam logic [7:0]  RunsMax      = 8'hFF;

  typedef enum logic [2:0] {
    FUNC_TICK     = 3'd0,
    FUNC_ADD      = 3'd1,
    FUNC_DELETE   = 3'd2,
    FUNC_DISPATCH = 3'd3,
    FUNC_CLEAR    = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    KIND_ADD_OK   = 2'd0,
    KIND_ADD_FULL = 2'd1,
    KIND_DUE      = 2'd2
  } kind_e;

  // operation token walking the slot chain
  typedef struct packed {
    logic        valid;
    func_e       func;
    logic [7:0]  task_id;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
    logic [2:0]  target_slot;
    logic        found;
    logic [3:0]  due_cnt;
  } tok_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [2:0] slot;
    logic [7:0] task_id;
  } res_t;

endpackage

`default_nettype wire

// File: src/tts_cell.sv
`default_nettype none

module tts_cell #(
  parameter int unsigned Index = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire tts_pkg::tok_t tok_i,
  output tts_pkg::tok_t      tok_o,
  output tts_pkg::res_t      res_o
);

  localparam bit         InRange = (Index < 8);
  localparam logic [2:0] SlotId  = 3'(Index % 8);

  logic        used_q, used_d;
  logic [7:0]  task_q, task_d;
  logic [15:0] left_q, left_d;
  logic [15:0] period_q, period_d;
  logic [7:0]  runs_q, runs_d;
  tts_pkg::tok_t tok_q, tok_d;
  logic        act;

  assign act = tok_i.valid && en_i;

  always_comb begin
    used_d   = used_q;
    task_d   = task_q;
    left_d   = left_q;
    period_d = period_q;
    runs_d   = runs_q;
    tok_d    = tok_i;
    res_o    = '0;
    case (tok_i.func)
      tts_pkg::FUNC_TICK: begin
        if (used_q) begin
          if (left_q == 16'd0) begin
            if (runs_q != tts_pkg::RunsMax) runs_d = runs_q + 8'd1;
            if (period_q != 16'd0) left_d = period_q - 16'd1;
          end else begin
            left_d = left_q - 16'd1;
          end
        end
      end
      tts_pkg::FUNC_ADD: begin
        if (!tok_i.found && !used_q) begin
          used_d        = 1'b1;
          task_d        = tok_i.task_id;
          left_d        = tok_i.first_delay;
          period_d      = tok_i.repeat_period;
          runs_d        = 8'd0;
          tok_d.found   = 1'b1;
          res_o.valid   = tok_i.valid;
          res_o.kind    = tts_pkg::KIND_ADD_OK;
          res_o.slot    = SlotId;
        end
      end
      tts_pkg::FUNC_DELETE: begin
        if (InRange && tok_i.target_slot == SlotId) begin
          used_d   = 1'b0;
          task_d   = 8'd0;
          left_d   = 16'd0;
          period_d = 16'd0;
          runs_d   = 8'd0;
        end
      end
      tts_pkg::FUNC_DISPATCH: begin
        if (used_q && runs_q != 8'd0 && tok_i.due_cnt < tts_pkg::MaxDue) begin
          res_o.valid   = tok_i.valid;
          res_o.kind    = tts_pkg::KIND_DUE;
          res_o.slot    = SlotId;
          res_o.task_id = task_q;
          tok_d.due_cnt = tok_i.due_cnt + 4'd1;
          runs_d        = runs_q - 8'd1;
          if (period_q == 16'd0) begin
            used_d   = 1'b0;
            task_d   = 8'd0;
            left_d   = 16'd0;
            period_d = 16'd0;
            runs_d   = 8'd0;
          end
        end
      end
      tts_pkg::FUNC_CLEAR: begin
        used_d   = 1'b0;
        task_d   = 8'd0;
        left_d   = 16'd0;
        period_d = 16'd0;
        runs_d   = 8'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= 1'b0;
      task_q   <= 8'd0;
      left_q   <= 16'd0;
      period_q <= 16'd0;
      runs_q   <= 8'd0;
      tok_q    <= '0;
    end else begin
      if (act) begin
        used_q   <= used_d;
        task_q   <= task_d;
        left_q   <= left_d;
        period_q <= period_d;
        runs_q   <= runs_d;
      end
      if (en_i) tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// File: src/tick_task_scheduler_table.sv
// Channel    Dir  Signals                     Contents (low bit up)
// s_axis     in   tvalid tready tdata tuser   tuser: func; tdata: task_id, first_delay,
//                                             repeat_period, target_slot
// m_axis     out  tvalid tready tdata tuser   tuser: kind; tdata: slot, due_task;
//                  tlast                      tlast: last
//
// One operation at a time; it walks the slot cells one per cycle while the
// output is not held, and takes no new transfer until the walk has ended.
// A held output register stalls the whole walk in place.
// Asynchronous reset empties every slot; no clearing pass is needed.
`default_nettype none

module tick_task_scheduler_table #(
  parameter int unsigned TASK_SLOTS = tts_pkg::TaskSlotsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // task_id, first_delay, repeat_period, target_slot
  input  wire logic [2:0]  s_axis_tuser,  // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // slot, due_task
  output logic [1:0]       m_axis_tuser,  // kind
  output logic             m_axis_tlast
);

  tts_pkg::tok_t tok [TASK_SLOTS+1];
  tts_pkg::res_t res [TASK_SLOTS];
  tts_pkg::res_t res_sel;
  tts_pkg::res_t pend_q, pend_d;
  tts_pkg::res_t out_d;
  logic          out_last_d, out_load;
  logic          busy_q, busy_d;
  logic          en;
  logic          m_valid_q;
  tts_pkg::kind_e m_kind_q;
  logic [2:0]    m_slot_q;
  logic [7:0]    m_task_q;
  logic          m_last_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !busy_q && en;

  always_comb begin
    tok[0]               = '0;
    tok[0].valid         = s_axis_tvalid && s_axis_tready;
    tok[0].func          = tts_pkg::func_e'(s_axis_tuser);
    tok[0].task_id       = s_axis_tdata[7:0];
    tok[0].first_delay   = s_axis_tdata[23:8];
    tok[0].repeat_period = s_axis_tdata[39:24];
    tok[0].target_slot   = s_axis_tdata[42:40];
  end

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    tts_cell #(
      .Index(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .tok_i (tok[i]),
      .tok_o (tok[i+1]),
      .res_o (res[i])
    );
  end

  always_comb begin
    res_sel = '0;
    for (int unsigned i = 0; i < TASK_SLOTS; i++) begin
      if (res[i].valid) res_sel = res[i];
    end
  end

  // one result held back so the final one can carry tlast
  always_comb begin
    pend_d     = pend_q;
    busy_d     = busy_q;
    out_d      = pend_q;
    out_last_d = 1'b0;
    out_load   = 1'b0;
    if (s_axis_tvalid && s_axis_tready) busy_d = 1'b1;
    if (en) begin
      if (res_sel.valid) begin
        out_load = pend_q.valid;
        pend_d   = res_sel;
      end else if (tok[TASK_SLOTS].valid) begin
        busy_d     = 1'b0;
        out_last_d = 1'b1;
        if (pend_q.valid) begin
          out_load     = 1'b1;
          pend_d.valid = 1'b0;
        end else if (tok[TASK_SLOTS].func == tts_pkg::FUNC_ADD &&
                     !tok[TASK_SLOTS].found) begin
          out_load      = 1'b1;
          out_d         = '0;
          out_d.kind    = tts_pkg::KIND_ADD_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pend_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
      if (en) m_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && out_load) begin
      m_kind_q <= out_d.kind;
      m_slot_q <= out_d.slot;
      m_task_q <= out_d.task_id;
      m_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_task_q, m_slot_q};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

// File: src/tts_checker.sv
`default_nettype none

module tts_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_add_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tts_pkg::KIND_ADD_OK ||
                      m_axis_tuser == tts_pkg::KIND_ADD_FULL) |-> m_axis_tlast)
    else $error("add result without tlast");

  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == tts_pkg::KIND_ADD_FULL
      |-> m_axis_tdata[10:0] == 11'd0)
    else $error("table-full result carries slot or task");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second operation taken during walk");

endmodule

bind tick_task_scheduler_table tts_checker u_tts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned TaskSlots = tts_pkg::TaskSlotsDef;
  localparam int unsigned TailCycles = 4 * (TaskSlots + 1);

  typedef struct {
    logic [2:0]  func;
    logic [7:0]  task_id;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
    logic [2:0]  target_slot;
  } op_t;

  typedef struct {
    tts_pkg::kind_e kind;
    logic [2:0]     slot;
    logic [7:0]     due_task;
    logic           last;
  } report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // task_id, first_delay, repeat_period, target_slot
  logic [2:0]  s_axis_tuser = '0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // slot, due_task
  logic [1:0]  m_axis_tuser;       // kind
  logic        m_axis_tlast;

  op_t         pending_ops[$];
  report_t     expected_reports[$];

  logic        slot_used[TaskSlots];
  logic [7:0]  slot_tid[TaskSlots];
  logic [15:0] slot_count[TaskSlots];
  logic [15:0] slot_period[TaskSlots];
  logic [7:0]  slot_runs[TaskSlots];

  int unsigned fails = 0;
  int unsigned cyc = 0;
  int unsigned n_sent = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_next;
  int unsigned hold_cnt = 0;
  logic        long_hold = 1'b0;
  logic        hold_done = 1'b0;
  op_t         tx_op;
  report_t     rx_exp;

  tick_task_scheduler_table #(
    .TASK_SLOTS(TaskSlots)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic op_t mk_op(logic [2:0] f, logic [7:0] id, logic [15:0] d,
                                logic [15:0] p, logic [2:0] t);
    op_t o;
    o.func = f;
    o.task_id = id;
    o.first_delay = d;
    o.repeat_period = p;
    o.target_slot = t;
    return o;
  endfunction

  // no idling while bits 8:7 of the cycle counter are both zero
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cyc[8:7] == 2'b00) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic free_slot(int s);
    slot_used[s] = 1'b0;
    slot_tid[s] = '0;
    slot_count[s] = '0;
    slot_period[s] = '0;
    slot_runs[s] = '0;
  endtask

  task automatic step_scheduler(logic [2:0] func, logic [47:0] data);
    logic [7:0]  id;
    logic [15:0] delay;
    logic [15:0] period;
    logic [2:0]  target;
    report_t     batch[8];
    report_t     r;
    int          n;
    int          s;
    id = data[7:0];
    delay = data[23:8];
    period = data[39:24];
    target = data[42:40];
    n = 0;
    case (func)
      tts_pkg::FUNC_TICK: begin
        for (s = 0; s < TaskSlots; s++) begin
          if (slot_used[s]) begin
            if (slot_count[s] == 16'd0) begin
              if (slot_runs[s] != tts_pkg::RunsMax) slot_runs[s] = slot_runs[s] + 8'd1;
              if (slot_period[s] != 16'd0) slot_count[s] = slot_period[s] - 16'd1;
            end else begin
              slot_count[s] = slot_count[s] - 16'd1;
            end
          end
        end
      end
      tts_pkg::FUNC_ADD: begin
        s = 0;
        while (s < TaskSlots && slot_used[s]) s++;
        r.due_task = '0;
        r.last = 1'b1;
        if (s >= TaskSlots) begin
          r.kind = tts_pkg::KIND_ADD_FULL;
          r.slot = '0;
        end else begin
          slot_used[s] = 1'b1;
          slot_tid[s] = id;
          slot_count[s] = delay;
          slot_period[s] = period;
          slot_runs[s] = '0;
          r.kind = tts_pkg::KIND_ADD_OK;
          r.slot = 3'(s);
        end
        expected_reports.push_back(r);
      end
      tts_pkg::FUNC_DELETE: begin
        if (int'(target) < TaskSlots) free_slot(int'(target));
      end
      tts_pkg::FUNC_DISPATCH: begin
        for (s = 0; s < TaskSlots && n < int'(tts_pkg::MaxDue); s++) begin
          if (slot_used[s] && slot_runs[s] != 8'd0) begin
            batch[n].kind = tts_pkg::KIND_DUE;
            batch[n].slot = 3'(s);
            batch[n].due_task = slot_tid[s];
            batch[n].last = 1'b0;
            n++;
            slot_runs[s] = slot_runs[s] - 8'd1;
            if (slot_period[s] == 16'd0) free_slot(s);
          end
        end
        if (n > 0) batch[n - 1].last = 1'b1;
        for (s = 0; s < n; s++) expected_reports.push_back(batch[s]);
      end
      tts_pkg::FUNC_CLEAR: begin
        for (s = 0; s < TaskSlots; s++) free_slot(s);
      end
      default: begin
      end
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        step_scheduler(s_axis_tuser, s_axis_tdata);
        n_sent <= n_sent + 1;
      end
      if (tx_gap != 0 || pending_ops.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (tx_gap != 0) tx_gap <= tx_gap - 1;
      end else begin
        tx_op = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= tx_op.func;
        s_axis_tdata <= {5'd0, tx_op.target_slot, tx_op.repeat_period,
                         tx_op.first_delay, tx_op.task_id};
        tx_gap <= idle_len();
      end
    end
  end

  // long receiver hold-off in the middle of the random part
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rst_ni) begin
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        if (hold_cnt == 1) long_hold <= 1'b0;
      end else if (!hold_done && n_sent >= 320) begin
        long_hold <= 1'b1;
        hold_cnt <= 400;
        hold_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected transfer: kind %0d slot %0d due_task %0d last %0d",
                 m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tlast);
          fails++;
        end else begin
          rx_exp = expected_reports.pop_front();
          if (m_axis_tuser !== rx_exp.kind) begin
            $error("kind: expected %0d, actual %0d", rx_exp.kind, m_axis_tuser);
            fails++;
          end
          if (m_axis_tdata[2:0] !== rx_exp.slot) begin
            $error("slot: expected %0d, actual %0d", rx_exp.slot, m_axis_tdata[2:0]);
            fails++;
          end
          if (m_axis_tdata[10:3] !== rx_exp.due_task) begin
            $error("due_task: expected %0d, actual %0d", rx_exp.due_task,
                   m_axis_tdata[10:3]);
            fails++;
          end
          if (m_axis_tlast !== rx_exp.last) begin
            $error("last: expected %0d, actual %0d", rx_exp.last, m_axis_tlast);
            fails++;
          end
        end
      end
      if (rx_stall != 0) begin
        rx_stall <= rx_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        rx_next = idle_len();
        if (rx_next == 0) begin
          m_axis_tready <= !long_hold;
        end else begin
          m_axis_tready <= 1'b0;
          rx_stall <= rx_next - 1;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int          s;
    int unsigned r;
    op_t         o;

    for (s = 0; s < TaskSlots; s++) free_slot(s);

    // empty table, extremes of the add fields, one-shot and periodic runs
    pending_ops.push_back(mk_op(tts_pkg::FUNC_DISPATCH, 8'h3C, 16'h0000, 16'h0000, 3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_ADD, 8'hFF, 16'h0000, 16'h0000, 3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_ADD, 8'h00, 16'hFFFF, 16'hFFFF, 3'd7));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_ADD, 8'hA5, 16'h0001, 16'h0002, 3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0));
    // fill the table, then one add too many
    for (s = 0; s < 7; s++)
      pending_ops.push_back(mk_op(tts_pkg::FUNC_ADD, 8'(8'h10 + s), 16'(s), 16'(s & 1),
                                  3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd7));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_DELETE, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd3));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_ADD, 8'h77, 16'h0000, 16'h0003, 3'd0));
    // spare function codes do nothing
    for (s = int'(tts_pkg::FUNC_CLEAR) + 1; s < 8; s++)
      pending_ops.push_back(mk_op(3'(s), 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_CLEAR, 8'h00, 16'h0000, 16'h0000, 3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0));

    // run count saturation
    pending_ops.push_back(mk_op(tts_pkg::FUNC_ADD, 8'h5A, 16'h0000, 16'h0001, 3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_ADD, 8'hC3, 16'h0000, 16'h0000, 3'd0));
    for (s = 0; s < 260; s++)
      pending_ops.push_back(mk_op(tts_pkg::FUNC_TICK, 8'(s), 16'(s), 16'(s), 3'(s)));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0));
    pending_ops.push_back(mk_op(tts_pkg::FUNC_CLEAR, 8'h00, 16'h0000, 16'h0000, 3'd0));

    while (pending_ops.size() < 380) begin
      r = $urandom_range(0, 99);
      o.task_id = 8'($urandom);
      o.first_delay = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 6))
                                                    : 16'($urandom);
      o.repeat_period = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 5))
                                                      : 16'($urandom);
      o.target_slot = 3'($urandom);
      if (r < 45) o.func = tts_pkg::FUNC_TICK;
      else if (r < 65) o.func = tts_pkg::FUNC_ADD;
      else if (r < 83) o.func = tts_pkg::FUNC_DISPATCH;
      else if (r < 91) o.func = tts_pkg::FUNC_DELETE;
      else if (r < 94) o.func = tts_pkg::FUNC_CLEAR;
      else o.func = 3'($urandom_range(int'(tts_pkg::FUNC_CLEAR) + 1, 7));
      pending_ops.push_back(o);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fails == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
